@@ hdl/tilt_kalman_angle_bias_macros.svh @@
// Assertion macros shared by the tilt Kalman filter RTL.
// Uses the clk and arst_n names of the including module; no other dependencies.
`ifndef TILT_KALMAN_ANGLE_BIAS_MACROS_SVH
`define TILT_KALMAN_ANGLE_BIAS_MACROS_SVH

// Check that cons holds in the same cycle as ante
`define TKAB_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("tkab same-cycle check failed");

// Check that cons holds in the cycle after ante
`define TKAB_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("tkab next-cycle check failed");

`endif

@@ hdl/tkab_pkg.sv @@
// Shared types, codes and the update program of the tilt Kalman filter.
// No dependencies.
`timescale 1ns / 1ps
package tkab_pkg;

	// Sequencer operations
	typedef enum logic [1:0] {
		OP_ADD,
		OP_SUB,
		OP_MUL,
		OP_DIV
	} op_t;

	// Operand and destination registers of the datapath
	typedef enum logic [4:0] {
		R_ANG,
		R_BIAS,
		R_AA,
		R_AB,
		R_BA,
		R_BB,
		R_T,
		R_U,
		R_Y,
		R_S,
		R_K0,
		R_K1,
		R_MEAS,
		R_RATE,
		R_DT,
		R_QA,
		R_QB,
		R_R
	} rsel_t;

	typedef struct packed {
		op_t   op;
		rsel_t dst;
		rsel_t src_a;
		rsel_t src_b;
	} instr_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_ISSUE,
		S_WAIT,
		S_DONE
	} state_t;

	// Configuration register indexes
	localparam logic [1:0] CFG_ANGLE_NOISE = 2'd0;
	localparam logic [1:0] CFG_BIAS_NOISE  = 2'd1;
	localparam logic [1:0] CFG_MEAS_NOISE  = 2'd2;

	localparam logic [23:0] ANGLE_NOISE_RST = 24'd6554;
	localparam logic [23:0] BIAS_NOISE_RST  = 24'd19661;
	localparam logic [23:0] MEAS_NOISE_RST  = 24'd6554;

	localparam int PC_BITS = 5;
	localparam logic [PC_BITS-1:0] PROG_LAST = 5'd28;

	// One filter update: predict, gain, correct, shrink covariance
	function automatic instr_t prog_rom(logic [PC_BITS-1:0] pc);
		instr_t i;
		case (pc)
			5'd0:  i = '{OP_SUB, R_T,    R_RATE, R_BIAS};
			5'd1:  i = '{OP_MUL, R_T,    R_DT,   R_T};
			5'd2:  i = '{OP_ADD, R_ANG,  R_ANG,  R_T};
			5'd3:  i = '{OP_ADD, R_T,    R_BA,   R_AB};
			5'd4:  i = '{OP_MUL, R_T,    R_DT,   R_T};
			5'd5:  i = '{OP_SUB, R_T,    R_AA,   R_T};
			5'd6:  i = '{OP_MUL, R_U,    R_QA,   R_DT};
			5'd7:  i = '{OP_ADD, R_AA,   R_T,    R_U};
			5'd8:  i = '{OP_MUL, R_T,    R_DT,   R_BB};
			5'd9:  i = '{OP_SUB, R_AB,   R_AB,   R_T};
			5'd10: i = '{OP_SUB, R_BA,   R_BA,   R_T};
			5'd11: i = '{OP_MUL, R_T,    R_QB,   R_DT};
			5'd12: i = '{OP_ADD, R_BB,   R_BB,   R_T};
			5'd13: i = '{OP_SUB, R_Y,    R_MEAS, R_ANG};
			5'd14: i = '{OP_ADD, R_S,    R_AA,   R_R};
			5'd15: i = '{OP_DIV, R_K0,   R_AA,   R_S};
			5'd16: i = '{OP_DIV, R_K1,   R_BA,   R_S};
			5'd17: i = '{OP_MUL, R_T,    R_K0,   R_Y};
			5'd18: i = '{OP_ADD, R_ANG,  R_ANG,  R_T};
			5'd19: i = '{OP_MUL, R_T,    R_K1,   R_Y};
			5'd20: i = '{OP_ADD, R_BIAS, R_BIAS, R_T};
			// covariance shrink: ba and bb first, while aa and ab are still old
			5'd21: i = '{OP_MUL, R_T,    R_K1,   R_AA};
			5'd22: i = '{OP_SUB, R_BA,   R_BA,   R_T};
			5'd23: i = '{OP_MUL, R_T,    R_K1,   R_AB};
			5'd24: i = '{OP_SUB, R_BB,   R_BB,   R_T};
			5'd25: i = '{OP_MUL, R_T,    R_K0,   R_AA};
			5'd26: i = '{OP_SUB, R_AA,   R_AA,   R_T};
			5'd27: i = '{OP_MUL, R_T,    R_K0,   R_AB};
			5'd28: i = '{OP_SUB, R_AB,   R_AB,   R_T};
			default: i = '{OP_ADD, R_T, R_T, R_T};
		endcase
		return i;
	endfunction

endpackage

@@ hdl/tkab_mul.sv @@
// Bit-serial saturating signed fixed-point multiplier, one multiplier bit per cycle.
// Depends on nothing outside this file.
`timescale 1ns / 1ps
module tkab_mul #(
	parameter int WORD_BITS = 32,
	parameter int FRAC_BITS = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [WORD_BITS-1:0] a,
	input  logic [WORD_BITS-1:0] b,
	output logic                 done,
	output logic [WORD_BITS-1:0] result
);
	localparam int W = WORD_BITS;
	localparam int CNT_BITS = $clog2(W + 1);
	localparam logic [2*W-1:0] LIM_POS = ((2*W)'(1) << (W - 1)) - (2*W)'(1);

	logic                busy_q;
	logic                done_q;
	logic                neg_q;
	logic [W-1:0]        mcand_q;
	logic [2*W-1:0]      prod_q;
	logic [CNT_BITS-1:0] cnt_q;

	logic [W:0]     sum;
	logic [2*W-1:0] prod_next;
	logic [2*W-1:0] m;
	logic [2*W-1:0] lim;
	logic [2*W-1:0] clipped;

	function automatic logic [W-1:0] mag_of(logic [W-1:0] v);
		return v[W-1] ? (~v + W'(1)) : v;
	endfunction

	// Add the multiplicand when the low multiplier bit is set, then shift right
	always_comb begin
		sum = {1'b0, prod_q[2*W-1:W]} + (prod_q[0] ? {1'b0, mcand_q} : (W+1)'(0));
		prod_next = {sum, prod_q[W-1:1]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CNT_BITS'(1);
				if (cnt_q == CNT_BITS'(W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Operand and product shift registers
	always_ff @(posedge clk) begin
		if (start) begin
			mcand_q <= mag_of(a);
			prod_q  <= {{W{1'b0}}, mag_of(b)};
			neg_q   <= a[W-1] ^ b[W-1];
		end else if (busy_q) begin
			prod_q <= prod_next;
		end
	end

	// Drop the fraction bits, saturate and restore the sign
	always_comb begin
		m = prod_q >> FRAC_BITS;
		lim = LIM_POS + (2*W)'(neg_q);
		clipped = (m > lim) ? lim : m;
		result = neg_q ? (~clipped[W-1:0] + W'(1)) : clipped[W-1:0];
	end

	assign done = done_q;

endmodule

@@ hdl/tkab_div.sv @@
// Bit-serial restoring saturating signed fixed-point divider, one quotient bit per cycle.
// Depends on nothing outside this file.
`timescale 1ns / 1ps
module tkab_div #(
	parameter int WORD_BITS = 32,
	parameter int FRAC_BITS = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [WORD_BITS-1:0] num,
	input  logic [WORD_BITS-1:0] den,
	output logic                 done,
	output logic [WORD_BITS-1:0] result
);
	localparam int W = WORD_BITS;
	localparam int DVD = WORD_BITS + FRAC_BITS;
	localparam int CNT_BITS = $clog2(DVD + 1);
	localparam logic [DVD-1:0] LIM_POS = (DVD'(1) << (W - 1)) - DVD'(1);

	logic                busy_q;
	logic                done_q;
	logic                neg_q;
	logic                dz_q;
	logic [W-1:0]        ud_q;
	logic [W-1:0]        rem_q;
	logic [DVD-1:0]      dvd_q;
	logic [CNT_BITS-1:0] cnt_q;

	logic [W:0]     shifted;
	logic [W:0]     diff;
	logic           ge;
	logic [DVD-1:0] lim;
	logic [DVD-1:0] clipped;
	logic [W-1:0]   signed_q;

	function automatic logic [W-1:0] mag_of(logic [W-1:0] v);
		return v[W-1] ? (~v + W'(1)) : v;
	endfunction

	// Bring down one dividend bit and try the subtract
	always_comb begin
		shifted = {rem_q, dvd_q[DVD-1]};
		ge = shifted >= {1'b0, ud_q};
		diff = shifted - {1'b0, ud_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CNT_BITS'(1);
				if (cnt_q == CNT_BITS'(DVD - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Remainder and dividend/quotient shift registers
	always_ff @(posedge clk) begin
		if (start) begin
			ud_q  <= mag_of(den);
			rem_q <= '0;
			dvd_q <= {mag_of(num), {FRAC_BITS{1'b0}}};
			neg_q <= num[W-1] ^ den[W-1];
			dz_q  <= (den == '0);
		end else if (busy_q) begin
			rem_q <= ge ? diff[W-1:0] : shifted[W-1:0];
			dvd_q <= {dvd_q[DVD-2:0], ge};
		end
	end

	// Saturate the quotient, restore the sign, force zero on a zero divisor
	always_comb begin
		lim = LIM_POS + DVD'(neg_q);
		clipped = (dvd_q > lim) ? lim : dvd_q;
		signed_q = neg_q ? (~clipped[W-1:0] + W'(1)) : clipped[W-1:0];
		result = dz_q ? '0 : signed_q;
	end

	assign done = done_q;

endmodule

@@ hdl/tilt_kalman_angle_bias.sv @@
// Top level of the two-state tilt Kalman filter: register port, sequencer, datapath.
// Depends on tkab_pkg, tkab_mul, tkab_div and tilt_kalman_angle_bias_macros.svh.
`timescale 1ns / 1ps
// Usage:
//   Input channel (in_valid/in_ready) takes one beat of measured_angle, gyro_rate
//   and step_time. Output channel (out_valid/out_ready) gives one beat of
//   angle_estimate and bias_estimate per input beat, in order.
//   A micro-program steps through 29 operations on one shared bit-serial
//   multiplier and one bit-serial divider; adds and subtracts run in the
//   sequencer itself, and each multiply or divide is awaited before the next
//   operation issues. Throughput is one item per update; in_ready is high only
//   while no update runs.
//   The result lands in an output register; the next item is accepted while it
//   waits. A stalled receiver holds a finished update until the register frees.
//   Reset clears the filter state to zero and loads the noise registers with
//   their defaults (0.1, 0.3, 0.1). The APB port (pready always high) writes
//   and reads the three noise registers at byte addresses 0, 4 and 8.
module tilt_kalman_angle_bias #(
	parameter int WORD_BITS = 32,
	parameter int FRAC_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [3:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [24:0] measured_angle,
	input  logic signed [27:0] gyro_rate,
	input  logic [15:0]        step_time,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] angle_estimate,
	output logic signed [31:0] bias_estimate
);
	import tkab_pkg::*;
	`include "tilt_kalman_angle_bias_macros.svh"

	localparam int W = WORD_BITS;
	localparam int UP = (FRAC_BITS >= 16) ? FRAC_BITS - 16 : 0;
	localparam int DN = (FRAC_BITS < 16) ? 16 - FRAC_BITS : 0;
	localparam logic [63:0] IN_LIM = (64'd1 << (W - 1)) - 64'd1;
	localparam logic [63:0] OUT_LIM = 64'h7FFF_FFFF;

	// Configuration registers
	logic [23:0] angle_noise_q;
	logic [23:0] bias_noise_q;
	logic [23:0] meas_noise_q;

	// Filter state and scratch registers
	logic [W-1:0] ang_q, bias_q, aa_q, ab_q, ba_q, bb_q;
	logic [W-1:0] t_q, u_q, y_q, s_q, k0_q, k1_q;
	logic [W-1:0] meas_q, rate_q, dt_q;
	logic [W-1:0] qa, qb, rn;

	state_t              state_q, state_d;
	logic [PC_BITS-1:0]  pc_q, pc_d;
	instr_t              instr;
	logic [W-1:0]        opa, opb, alu_res, wr_data;
	logic                wr_en;
	logic                mul_start, div_start, mul_done, div_done;
	logic [W-1:0]        mul_res, div_res;
	logic                out_valid_q, out_load;
	logic [31:0]         angle_out_q, bias_out_q;
	logic                cfg_wr;

	// Q16.16 value into the internal format, saturated
	function automatic logic [W-1:0] to_int(logic signed [31:0] v);
		logic [63:0] m;
		logic [63:0] lim;
		m = v[31] ? (~{{32{v[31]}}, v} + 64'd1) : {32'd0, v};
		m = (m << UP) >> DN;
		lim = IN_LIM + {63'd0, v[31]};
		if (m > lim) m = lim;
		return v[31] ? (~m[W-1:0] + W'(1)) : m[W-1:0];
	endfunction

	// Internal value back to Q16.16, saturated to 32 bits
	function automatic logic [31:0] to_out(logic [W-1:0] v);
		logic [63:0] m;
		logic [63:0] lim;
		m = v[W-1] ? {{(64-W){1'b0}}, ~v + W'(1)} : {{(64-W){1'b0}}, v};
		m = (m << DN) >> UP;
		lim = OUT_LIM + {63'd0, v[W-1]};
		if (m > lim) m = lim;
		return v[W-1] ? (~m[31:0] + 32'd1) : m[31:0];
	endfunction

	// Saturating add or subtract
	function automatic logic [W-1:0] sat_addsub(logic [W-1:0] a, logic [W-1:0] b,
		logic sub);
		logic [W:0] s;
		s = sub ? ({a[W-1], a} - {b[W-1], b}) : ({a[W-1], a} + {b[W-1], b});
		if (s[W] != s[W-1]) begin
			return s[W] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
		end
		return s[W-1:0];
	endfunction

	function automatic logic [W-1:0] pick(rsel_t r);
		case (r)
			R_ANG:  return ang_q;
			R_BIAS: return bias_q;
			R_AA:   return aa_q;
			R_AB:   return ab_q;
			R_BA:   return ba_q;
			R_BB:   return bb_q;
			R_T:    return t_q;
			R_U:    return u_q;
			R_Y:    return y_q;
			R_S:    return s_q;
			R_K0:   return k0_q;
			R_K1:   return k1_q;
			R_MEAS: return meas_q;
			R_RATE: return rate_q;
			R_DT:   return dt_q;
			R_QA:   return qa;
			R_QB:   return qb;
			R_R:    return rn;
			default: return '0;
		endcase
	endfunction

	// Register port: write on the access beat, read back any time
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			angle_noise_q <= ANGLE_NOISE_RST;
			bias_noise_q  <= BIAS_NOISE_RST;
			meas_noise_q  <= MEAS_NOISE_RST;
		end else if (cfg_wr) begin
			case (paddr[3:2])
				CFG_ANGLE_NOISE: angle_noise_q <= pwdata[23:0];
				CFG_BIAS_NOISE:  bias_noise_q  <= pwdata[23:0];
				CFG_MEAS_NOISE:  meas_noise_q  <= pwdata[23:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			CFG_ANGLE_NOISE: prdata = {8'd0, angle_noise_q};
			CFG_BIAS_NOISE:  prdata = {8'd0, bias_noise_q};
			CFG_MEAS_NOISE:  prdata = {8'd0, meas_noise_q};
			default:         prdata = 32'd0;
		endcase
	end

	assign qa = to_int({8'd0, angle_noise_q});
	assign qb = to_int({8'd0, bias_noise_q});
	assign rn = to_int({8'd0, meas_noise_q});

	// Operand selection and the combinational add/subtract
	assign instr = prog_rom(pc_q);
	always_comb begin
		opa = pick(instr.src_a);
		opb = pick(instr.src_b);
	end
	assign alu_res = sat_addsub(opa, opb, instr.op == OP_SUB);

	tkab_mul #(.WORD_BITS(WORD_BITS), .FRAC_BITS(FRAC_BITS)) u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a      (opa),
		.b      (opb),
		.done   (mul_done),
		.result (mul_res)
	);

	tkab_div #(.WORD_BITS(WORD_BITS), .FRAC_BITS(FRAC_BITS)) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (opa),
		.den    (opb),
		.done   (div_done),
		.result (div_res)
	);

	// Sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			pc_q    <= '0;
		end else begin
			state_q <= state_d;
			pc_q    <= pc_d;
		end
	end

	// Next state, unit starts and write-back
	always_comb begin
		state_d   = state_q;
		pc_d      = pc_q;
		mul_start = 1'b0;
		div_start = 1'b0;
		wr_en     = 1'b0;
		wr_data   = alu_res;
		out_load  = 1'b0;
		in_ready  = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					state_d = S_ISSUE;
					pc_d    = '0;
				end
			end
			S_ISSUE: begin
				case (instr.op)
					OP_MUL: begin
						mul_start = 1'b1;
						state_d   = S_WAIT;
					end
					OP_DIV: begin
						div_start = 1'b1;
						state_d   = S_WAIT;
					end
					default: begin
						wr_en = 1'b1;
						if (pc_q == PROG_LAST) begin
							state_d = S_DONE;
						end else begin
							pc_d = pc_q + PC_BITS'(1);
						end
					end
				endcase
			end
			S_WAIT: begin
				if (mul_done || div_done) begin
					wr_en   = 1'b1;
					wr_data = mul_done ? mul_res : div_res;
					state_d = S_ISSUE;
					pc_d    = pc_q + PC_BITS'(1);
				end
			end
			S_DONE: begin
				if (!out_valid_q || out_ready) begin
					out_load = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// Latch the converted input beat
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			meas_q <= to_int(32'(measured_angle));
			rate_q <= to_int(32'(gyro_rate));
			dt_q   <= to_int({16'd0, step_time});
		end
	end

	// Filter state write-back
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ang_q  <= '0;
			bias_q <= '0;
			aa_q   <= '0;
			ab_q   <= '0;
			ba_q   <= '0;
			bb_q   <= '0;
		end else if (wr_en) begin
			case (instr.dst)
				R_ANG:  ang_q  <= wr_data;
				R_BIAS: bias_q <= wr_data;
				R_AA:   aa_q   <= wr_data;
				R_AB:   ab_q   <= wr_data;
				R_BA:   ba_q   <= wr_data;
				R_BB:   bb_q   <= wr_data;
				default: ;
			endcase
		end
	end

	// Scratch write-back
	always_ff @(posedge clk) begin
		if (wr_en) begin
			case (instr.dst)
				R_T:  t_q  <= wr_data;
				R_U:  u_q  <= wr_data;
				R_Y:  y_q  <= wr_data;
				R_S:  s_q  <= wr_data;
				R_K0: k0_q <= wr_data;
				R_K1: k1_q <= wr_data;
				default: ;
			endcase
		end
	end

	// Output register: hold the beat until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			angle_out_q <= to_out(ang_q);
			bias_out_q  <= to_out(bias_q);
		end
	end

	assign out_valid      = out_valid_q;
	assign angle_estimate = angle_out_q;
	assign bias_estimate  = bias_out_q;

	`TKAB_ASSERT_NEXT(a_accept_starts, in_valid && in_ready, state_q == S_ISSUE && pc_q == '0)
	`TKAB_ASSERT_IMPL(a_mul_done_in_wait, mul_done, state_q == S_WAIT)
	`TKAB_ASSERT_IMPL(a_div_done_in_wait, div_done, state_q == S_WAIT)
	`TKAB_ASSERT_IMPL(a_pc_in_program, state_q != S_IDLE, pc_q <= PROG_LAST)
	`TKAB_ASSERT_NEXT(a_done_loads_output, state_q == S_DONE && !out_valid_q, out_valid_q)

endmodule

@@ dv/tilt_kalman_angle_bias_checker.sv @@
// Scoreboard for the tilt Kalman filter: snoops the register port and both streams,
// predicts each angle and bias estimate, and compares. Depends on tkab_pkg.
`timescale 1ns / 1ps
module tilt_kalman_angle_bias_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [3:0]         paddr,
	input  logic [31:0]        pwdata,
	input  logic               in_valid,
	input  logic               in_ready,
	input  logic signed [24:0] measured_angle,
	input  logic signed [27:0] gyro_rate,
	input  logic [15:0]        step_time,
	input  logic               out_valid,
	input  logic               out_ready,
	input  logic signed [31:0] angle_estimate,
	input  logic signed [31:0] bias_estimate,
	output int                 fail_count,
	output int                 pending
);
	import tkab_pkg::*;

	localparam longint WMAX = 64'sd2147483647;
	localparam longint WMIN = -64'sd2147483648;

	typedef struct {
		logic signed [31:0] angle;
		logic signed [31:0] bias;
	} estimate_t;

	estimate_t estimates_q[$];

	// filter state and noise registers, Q16.16 held in 64-bit integers
	longint ang, bias, p_aa, p_ab, p_ba, p_bb;
	longint q_angle, q_bias, r_meas;

	function automatic longint fx_sat(longint v);
		if (v > WMAX) return WMAX;
		if (v < WMIN) return WMIN;
		return v;
	endfunction

	function automatic longint fx_add(longint a, longint b);
		return fx_sat(a + b);
	endfunction

	function automatic longint fx_sub(longint a, longint b);
		return fx_sat(a - b);
	endfunction

	// exact product, magnitude shifted down (toward zero), then saturated
	function automatic longint fx_mul(longint a, longint b);
		longint p, m;
		p = a * b;
		m = (p < 0) ? -p : p;
		m = m >>> 16;
		return fx_sat((p < 0) ? -m : m);
	endfunction

	function automatic longint fx_div(longint n, longint d);
		longint un, ud, q;
		if (d == 0) return 0;
		un = (n < 0) ? -n : n;
		ud = (d < 0) ? -d : d;
		q = (un <<< 16) / ud;
		return fx_sat(((n < 0) != (d < 0)) ? -q : q);
	endfunction

	// one predict/correct step; push the resulting estimates
	task automatic kalman_update(longint meas, longint rate, longint dt);
		longint y, s, k0, k1, a0, b0;
		estimate_t e;
		k0 = 0;
		k1 = 0;
		ang = fx_add(ang, fx_mul(dt, fx_sub(rate, bias)));
		p_aa = fx_add(fx_sub(p_aa, fx_mul(dt, fx_add(p_ba, p_ab))), fx_mul(q_angle, dt));
		p_ab = fx_sub(p_ab, fx_mul(dt, p_bb));
		p_ba = fx_sub(p_ba, fx_mul(dt, p_bb));
		p_bb = fx_add(p_bb, fx_mul(q_bias, dt));
		y = fx_sub(meas, ang);
		s = fx_add(p_aa, r_meas);
		// zero divisor: no correction
		if (s != 0) begin
			k0 = fx_div(p_aa, s);
			k1 = fx_div(p_ba, s);
		end
		ang = fx_add(ang, fx_mul(k0, y));
		bias = fx_add(bias, fx_mul(k1, y));
		a0 = p_aa;
		b0 = p_ab;
		p_aa = fx_sub(p_aa, fx_mul(k0, a0));
		p_ab = fx_sub(p_ab, fx_mul(k0, b0));
		p_ba = fx_sub(p_ba, fx_mul(k1, a0));
		p_bb = fx_sub(p_bb, fx_mul(k1, b0));
		e.angle = ang[31:0];
		e.bias = bias[31:0];
		estimates_q.push_back(e);
	endtask

	always @(posedge clk or negedge arst_n) begin
		estimate_t e;
		if (!arst_n) begin
			ang = 0; bias = 0;
			p_aa = 0; p_ab = 0; p_ba = 0; p_bb = 0;
			q_angle = ANGLE_NOISE_RST;
			q_bias = BIAS_NOISE_RST;
			r_meas = MEAS_NOISE_RST;
			estimates_q.delete();
			fail_count = 0;
		end else begin
			// register writes; an index past the last register is dropped
			if (psel && penable && pwrite) begin
				case (paddr[3:2])
					CFG_ANGLE_NOISE: q_angle = longint'(pwdata[23:0]);
					CFG_BIAS_NOISE:  q_bias = longint'(pwdata[23:0]);
					CFG_MEAS_NOISE:  r_meas = longint'(pwdata[23:0]);
					default: ;
				endcase
			end
			// compare result beat against the oldest prediction
			if (out_valid && out_ready) begin
				if (estimates_q.size() == 0) begin
					$error("unexpected result beat: angle %0d bias %0d",
						angle_estimate, bias_estimate);
					fail_count++;
				end else begin
					e = estimates_q.pop_front();
					if (angle_estimate !== e.angle) begin
						$error("angle_estimate: expected %0d, got %0d", e.angle, angle_estimate);
						fail_count++;
					end
					if (bias_estimate !== e.bias) begin
						$error("bias_estimate: expected %0d, got %0d", e.bias, bias_estimate);
						fail_count++;
					end
				end
			end
			// predict for each accepted input beat
			if (in_valid && in_ready)
				kalman_update(longint'(measured_angle), longint'(gyro_rate),
					longint'({1'b0, step_time}));
		end
		pending = estimates_q.size();
	end
endmodule

@@ dv/tb_tilt_kalman_angle_bias.sv @@
// Testbench top for the tilt Kalman filter: drives register writes and sample beats
// with random gaps and stalls; depends on tkab_pkg, the RTL and the checker.
`timescale 1ns / 1ps
module tb_tilt_kalman_angle_bias;
	import tkab_pkg::*;

	localparam int STALL_MAX = 12;
	localparam int DRAIN_CYCLES = 600;
	localparam int WATCHDOG_LIMIT = 20000;
	localparam int RANDOM_ITEMS = 680;
	localparam int ANGLE_LIM = 11796480;

	logic clk, arst_n;
	logic psel, penable, pwrite, pready;
	logic [3:0] paddr;
	logic [31:0] pwdata, prdata;
	logic in_valid, in_ready, out_valid, out_ready;
	logic signed [24:0] measured_angle;
	logic signed [27:0] gyro_rate;
	logic [15:0] step_time;
	logic signed [31:0] angle_estimate, bias_estimate;
	int fail_count, pending;
	int n_items, n_writes, idle_cycles;
	bit no_gaps, no_stalls;

	tilt_kalman_angle_bias DUT (.*);

	tilt_kalman_angle_bias_checker u_checker (.*);

	always begin
		clk = 1'b1; #2;
		clk = 1'b0; #2;
	end

	// draw an idle count, or none in a no-idle stretch
	function automatic int draw_idle(bit suppress);
		if (suppress) return 0;
		return int'($urandom_range(0, STALL_MAX));
	endfunction

	task automatic send_sample(logic signed [24:0] ang, logic signed [27:0] rate,
			logic [15:0] dt);
		int gap;
		gap = draw_idle(no_gaps);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		measured_angle <= ang;
		gyro_rate <= rate;
		step_time <= dt;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		n_items++;
	endtask

	// setup then access phase; register latches on the access edge
	task automatic reg_write(logic [1:0] idx, logic [23:0] val);
		psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
		paddr <= {idx, 2'b00}; pwdata <= {8'h00, val};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
		n_writes++;
	endtask

	// hold the sender until every estimate has come back
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_noise(logic [23:0] qa, logic [23:0] qb, logic [23:0] r);
		drain();
		reg_write(CFG_ANGLE_NOISE, qa);
		reg_write(CFG_BIAS_NOISE, qb);
		reg_write(CFG_MEAS_NOISE, r);
	endtask

	task automatic random_sample();
		logic signed [24:0] a;
		logic signed [27:0] r;
		logic [15:0] dt;
		int kind;
		kind = int'($urandom_range(0, 9));
		if (kind < 3) begin
			// full rate and step fields, angle within +-180 deg
			a = 25'(int'($urandom_range(0, 2 * ANGLE_LIM)) - ANGLE_LIM);
			r = 28'($urandom);
			dt = 16'($urandom);
		end else begin
			// plausible sensor traffic: tilt within 90 deg, rate within 250 deg/s
			a = 25'(int'($urandom_range(0, 2 * 90 * 65536)) - 90 * 65536);
			r = 28'(int'($urandom_range(0, 2 * 250 * 65536)) - 250 * 65536);
			dt = 16'($urandom_range(0, 3000));
		end
		send_sample(a, r, dt);
	endtask

	// receiver: random stalls between result beats
	initial begin
		int stall;
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			stall = draw_idle(no_stalls);
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			@(posedge clk);
			while (!out_valid) @(posedge clk);
		end
	end

	// watchdog: count cycles with no beat on any port
	initial begin
		idle_cycles = 0;
		forever begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready) || (psel && penable))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("timeout: no activity for %0d cycles", WATCHDOG_LIMIT);
				$display("CHECKS FAILED");
				$finish;
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
		in_valid = 1'b0; measured_angle = '0; gyro_rate = '0; step_time = '0;
		n_items = 0; n_writes = 0;
		no_gaps = 1'b0; no_stalls = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: rate and step field extremes, angle at +-180 deg, at default noise
		send_sample(25'sd0, 28'sd0, 16'd0);
		send_sample(25'sd11796480, 28'sd0, 16'd65535);
		send_sample(-25'sd11796480, 28'sd0, 16'd65535);
		send_sample(25'sd0, 28'sd134217727, 16'd65535);
		send_sample(25'sd0, -28'sd134217728, 16'd65535);
		send_sample(25'sd11796480, 28'sd134217727, 16'd65535);
		send_sample(-25'sd11796480, -28'sd134217728, 16'd1);
		send_sample(25'sd65536, 28'sd655360, 16'd655);

		// directed: extreme noise settings, smallest then largest measurement noise
		set_noise(24'hFFFFFF, 24'hFFFFFF, 24'd1);
		send_sample(25'sd11796480, 28'sd134217727, 16'd65535);
		send_sample(-25'sd11796480, -28'sd134217728, 16'd65535);
		send_sample(25'sd0, 28'sd0, 16'd0);
		set_noise(24'd0, 24'd0, 24'hFFFFFF);
		send_sample(25'sd100, -28'sd100, 16'd65535);
		send_sample(-25'sd11796480, 28'sd134217727, 16'd32768);
		send_sample(25'sd0, 28'sd0, 16'd0);

		// write past the last register: must be dropped
		drain();
		reg_write(2'd3, 24'h123456);
		set_noise(ANGLE_NOISE_RST, BIAS_NOISE_RST, MEAS_NOISE_RST);
		send_sample(25'sd655360, 28'sd6553600, 16'd655);

		// random phases under different noise settings and idling styles
		for (int ph = 0; ph < 5; ph++) begin
			if (ph > 0)
				set_noise(24'($urandom), 24'($urandom), 24'($urandom_range(1, 24'hFFFFFF)));
			no_gaps = (ph == 2);
			no_stalls = (ph == 2) || (ph == 4);
			for (int i = 0; i < RANDOM_ITEMS / 5; i++) random_sample();
		end
		no_gaps = 1'b0;
		no_stalls = 1'b0;

		drain();
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("covered %0d samples and %0d register writes over default, extreme",
			n_items, n_writes);
		$display("and random noise settings, with random gaps and result stalls");
		if (fail_count == 0 && pending == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end
endmodule
